// ===== sv/idac_pkg.sv =====
// Shared types, constants and helper functions for the integer to decimal ASCII block.
// Used by idac_dabble, idac_emit and integer_to_decimal_ascii_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package idac_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_CHARS  = 20;
  localparam int NUM_DIGITS = ((MAX_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
  localparam int CHR_CNT_W  = $clog2(MAX_CHARS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [1:0] {
    TW_8  = 2'd0,
    TW_16 = 2'd1,
    TW_32 = 2'd2,
    TW_64 = 2'd3
  } type_width_e;

  typedef struct packed {
    logic [63:0] operand_bits;
    logic [1:0]  type_width;
    logic        is_signed;
  } in_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } out_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] nbits;
  } conv_ctrl_t;

  typedef struct packed {
    logic load;
    logic neg;
  } emit_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_TEXT
  } top_state_e;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SIGN,
    E_DIGIT
  } emit_state_e;

  function automatic logic [CNT_W-1:0] width_bits(input logic [1:0] tw);
    int w;
    begin
      case (type_width_e'(tw))
        TW_8:    w = 8;
        TW_16:   w = 16;
        TW_32:   w = 32;
        TW_64:   w = 64;
        default: w = 64;
      endcase
      if (w > MAX_WIDTH) begin
        w = MAX_WIDTH;
      end
      width_bits = CNT_W'(w);
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/idac_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add three), one operand bit per cycle.
// Depends on idac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idac_dabble (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire idac_pkg::conv_ctrl_t        ctrl_i,
  input  wire logic [idac_pkg::MAX_WIDTH-1:0] aligned_i,
  output logic [idac_pkg::BCD_W-1:0]       digits_o,
  output logic                             done_o
);

  logic [idac_pkg::MAX_WIDTH-1:0] sh_q, sh_d;
  logic [idac_pkg::BCD_W-1:0]     bcd_q, bcd_d, adj;
  logic [idac_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           run_q, run_d;
  logic                           done_q, done_d;

  always_comb begin
    for (int i = 0; i < idac_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (ctrl_i.load) begin
      sh_d  = aligned_i;
      bcd_d = '0;
      cnt_d = ctrl_i.nbits;
      run_d = 1'b1;
    end else if (run_q) begin
      sh_d  = {sh_q[idac_pkg::MAX_WIDTH-2:0], 1'b0};
      bcd_d = {adj[idac_pkg::BCD_W-2:0], sh_q[idac_pkg::MAX_WIDTH-1]};
      cnt_d = cnt_q - idac_pkg::CNT_W'(1);
      if (cnt_q == idac_pkg::CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign digits_o = bcd_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

// ===== sv/idac_emit.sv =====
// Character emitter: sends the sign, drops leading zero digits and sends one digit per cycle.
// Depends on idac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idac_emit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire idac_pkg::emit_ctrl_t        ctrl_i,
  input  wire logic [idac_pkg::BCD_W-1:0]  digits_i,
  output logic                             strobe_o,
  output idac_pkg::out_t                   result_o,
  output logic                             done_o
);

  idac_pkg::emit_state_e          est_q, est_d;
  logic [idac_pkg::BCD_W-1:0]     dig_q, dig_d;
  logic [idac_pkg::DIG_CNT_W-1:0] rem_q, rem_d;
  logic [idac_pkg::CHR_CNT_W-1:0] chars_q, chars_d;
  logic                           seen_q, seen_d;
  logic [3:0]                     top_dig;
  logic                           chars_last;
  logic                           out_valid;
  idac_pkg::out_t                 out_d;
  logic                           strobe_q;
  idac_pkg::out_t                 res_q;

  assign top_dig    = dig_q[idac_pkg::BCD_W-1 -: 4];
  assign chars_last = (chars_q == idac_pkg::CHR_CNT_W'(idac_pkg::MAX_CHARS - 1));

  always_comb begin
    est_d     = est_q;
    dig_d     = dig_q;
    rem_d     = rem_q;
    chars_d   = chars_q;
    seen_d    = seen_q;
    out_valid = 1'b0;
    out_d     = '0;
    case (est_q)
      idac_pkg::E_IDLE: begin
        if (ctrl_i.load) begin
          dig_d   = digits_i;
          rem_d   = idac_pkg::DIG_CNT_W'(idac_pkg::NUM_DIGITS);
          chars_d = '0;
          seen_d  = 1'b0;
          est_d   = ctrl_i.neg ? idac_pkg::E_SIGN : idac_pkg::E_DIGIT;
        end
      end
      idac_pkg::E_SIGN: begin
        out_valid        = 1'b1;
        out_d.ascii_char = idac_pkg::CHAR_MINUS;
        out_d.last_char  = chars_last;
        chars_d          = chars_q + idac_pkg::CHR_CNT_W'(1);
        est_d            = chars_last ? idac_pkg::E_IDLE : idac_pkg::E_DIGIT;
      end
      idac_pkg::E_DIGIT: begin
        dig_d = {dig_q[idac_pkg::BCD_W-5:0], 4'd0};
        rem_d = rem_q - idac_pkg::DIG_CNT_W'(1);
        if (top_dig != 4'd0 || seen_q || rem_q == idac_pkg::DIG_CNT_W'(1)) begin
          out_valid        = 1'b1;
          out_d.ascii_char = idac_pkg::CHAR_ZERO + {4'd0, top_dig};
          out_d.last_char  = (rem_q == idac_pkg::DIG_CNT_W'(1)) || chars_last;
          chars_d          = chars_q + idac_pkg::CHR_CNT_W'(1);
          seen_d           = 1'b1;
          if (out_d.last_char) begin
            est_d = idac_pkg::E_IDLE;
          end
        end
      end
      default: begin
        est_d = idac_pkg::E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q    <= idac_pkg::E_IDLE;
      strobe_q <= 1'b0;
      rem_q    <= '0;
      chars_q  <= '0;
      seen_q   <= 1'b0;
    end else begin
      est_q    <= est_d;
      strobe_q <= out_valid;
      rem_q    <= rem_d;
      chars_q  <= chars_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    res_q <= out_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;
  assign done_o   = out_valid & out_d.last_char;

endmodule

`default_nettype wire

// ===== sv/integer_to_decimal_ascii_top.sv =====
// Top level of the integer to decimal ASCII block: operand preparation and sequencing.
// Depends on idac_pkg, idac_dabble and idac_emit.
`timescale 1ns / 1ps
`default_nettype none

// An item (operand bits, width code, signedness) is accepted at a rising edge where start
// is high and busy is low. The operand is masked to its width, a negative signed value is
// negated, and the magnitude is shifted MSB first into a BCD register, one bit per cycle.
// The digit register is then scanned one digit per cycle: leading zeros are dropped, a
// minus sign goes first for a negative value, and each character appears on result_o for
// one cycle with strobe high; last_char marks the final one. Zero gives a single '0'.
// How long one item occupies the block is set by the serial conversion, the scan over
// all twenty digit positions and the minus sign if there is one. busy stays high until
// the last character is produced; the next item can be taken while that character is
// still on the output register. The receiver cannot stall: every strobe is taken.
// Reset clears all control state; no item is in flight afterwards and busy is low.
module integer_to_decimal_ascii_top (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire idac_pkg::in_t   item_i,
  output logic                 strobe,
  output idac_pkg::out_t       result_o
);

  idac_pkg::top_state_e           st_q, st_d;
  logic                           neg_q, neg_d;
  logic [idac_pkg::CNT_W-1:0]     w;
  logic [idac_pkg::MAX_WIDTH-1:0] val, mask, mag, aligned;
  logic                           neg_in;
  logic                           accept;
  idac_pkg::conv_ctrl_t           conv_ctrl;
  idac_pkg::emit_ctrl_t           emit_ctrl;
  logic [idac_pkg::BCD_W-1:0]     digits;
  logic                           conv_done;
  logic                           emit_done;

  assign w   = idac_pkg::width_bits(item_i.type_width);
  assign val = item_i.operand_bits[idac_pkg::MAX_WIDTH-1:0];

  always_comb begin
    if (w >= idac_pkg::CNT_W'(idac_pkg::MAX_WIDTH)) begin
      mask = '1;
    end else begin
      mask = (idac_pkg::MAX_WIDTH'(1) << w) - idac_pkg::MAX_WIDTH'(1);
    end
  end

  assign neg_in  = item_i.is_signed & (|(val & (mask ^ (mask >> 1))));
  assign mag     = neg_in ? ((~val + idac_pkg::MAX_WIDTH'(1)) & mask) : (val & mask);
  assign aligned = mag << (idac_pkg::CNT_W'(idac_pkg::MAX_WIDTH) - w);

  assign busy   = (st_q != idac_pkg::ST_IDLE);
  assign accept = start & ~busy;

  always_comb begin
    st_d            = st_q;
    neg_d           = neg_q;
    conv_ctrl.load  = 1'b0;
    conv_ctrl.nbits = w;
    emit_ctrl.load  = 1'b0;
    emit_ctrl.neg   = neg_q;
    case (st_q)
      idac_pkg::ST_IDLE: begin
        if (accept) begin
          conv_ctrl.load = 1'b1;
          neg_d          = neg_in;
          st_d           = idac_pkg::ST_CONV;
        end
      end
      idac_pkg::ST_CONV: begin
        if (conv_done) begin
          emit_ctrl.load = 1'b1;
          st_d           = idac_pkg::ST_TEXT;
        end
      end
      idac_pkg::ST_TEXT: begin
        if (emit_done) begin
          st_d = idac_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = idac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= idac_pkg::ST_IDLE;
      neg_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      neg_q <= neg_d;
    end
  end

  idac_dabble u_dabble (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (conv_ctrl),
    .aligned_i (aligned),
    .digits_o  (digits),
    .done_o    (conv_done)
  );

  idac_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (emit_ctrl),
    .digits_i (digits),
    .strobe_o (strobe),
    .result_o (result_o),
    .done_o   (emit_done)
  );

endmodule

`default_nettype wire
